### hw/rtl/ovn_pkg.sv
// ----------------------------------------------------------------------------
// ovn_pkg
// Shared types and constants of the octave value noise block.
// ----------------------------------------------------------------------------
package ovn_pkg;

    // item kinds carried in tuser
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // configuration register indexes
    localparam logic REG_OCTAVE_COUNT = 1'b0;
    localparam logic REG_BIAS         = 1'b1;

    localparam int OCT_W    = 4;
    localparam int BIAS_W   = 15;
    localparam int SAMPLE_W = 16;
    localparam int COORD_W  = 8;
    localparam int STORE_AW = 16;
    localparam int WEIGHT_SHIFT = 12;

    localparam logic [OCT_W-1:0]  OCT_COUNT_RST = 4'd5;
    localparam logic [BIAS_W-1:0] BIAS_RST      = 15'd2867;
    localparam logic [BIAS_W-1:0] BIAS_LOW      = 15'd1024;
    localparam logic [BIAS_W-1:0] BIAS_HIGH     = 15'd16384;

    typedef struct packed {
        logic [OCT_W-1:0]  octave_count;
        logic [BIAS_W-1:0] bias;
    } cfg_t;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

### hw/rtl/ovn_div.sv
// ----------------------------------------------------------------------------
// ovn_div
// Shared restoring divider, one quotient bit per cycle, variable length.
// ----------------------------------------------------------------------------
module ovn_div import ovn_pkg::*;
#(
    parameter int DW  = 16,
    parameter int DVW = 16,
    parameter int NBW = 5
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [NBW-1:0] nbits,     // dividend must fit in nbits
    input  logic [DW-1:0]  dividend,
    input  logic [DVW-1:0] divisor,
    output logic           done,
    output logic [DW-1:0]  quot,
    output logic [DVW-1:0] rem
);

    localparam int IXW = (DW > 1) ? $clog2(DW) : 1;

    logic           run_reg;
    logic           done_reg;
    logic [NBW-1:0] cnt_reg;
    logic [DW-1:0]  num_reg;
    logic [DVW-1:0] den_reg;
    logic [DVW-1:0] rem_reg;
    logic [DW-1:0]  quot_reg;

    logic [NBW-1:0] cnt_m1;
    logic           cur_bit;
    logic [DVW:0]   trial;
    logic           fits;
    logic [DVW-1:0] rem_next;
    logic [DW-1:0]  quot_next;

    assign cnt_m1  = cnt_reg - 1'b1;
    assign cur_bit = num_reg[cnt_m1[IXW-1:0]];
    assign trial   = {rem_reg, cur_bit};
    assign fits    = (trial >= {1'b0, den_reg});

    always_comb
    begin
        if (fits)
        begin
            rem_next = DVW'(trial - {1'b0, den_reg});
        end
        else
        begin
            rem_next = trial[DVW-1:0];
        end
        quot_next = {quot_reg[DW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= nbits;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_m1;
                if (cnt_reg == NBW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= dividend;
            den_reg  <= divisor;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !run_reg)
        else $error("divider started while running");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !run_reg)
        else $error("divider done while still running");

endmodule

### hw/rtl/ovn_seed_ram.sv
// ----------------------------------------------------------------------------
// ovn_seed_ram
// Seed sample store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ovn_seed_ram import ovn_pkg::*;
(
    input  logic                clk,
    input  logic                we,
    input  logic [STORE_AW-1:0] waddr,
    input  logic [SAMPLE_W-1:0] wdata,
    input  logic [STORE_AW-1:0] raddr,
    output logic [SAMPLE_W-1:0] rdata
);

    localparam int DEPTH = 1 << STORE_AW;

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/ovn_core.sv
// ----------------------------------------------------------------------------
// ovn_core
// Query sequencer: octave loop over one multiplier and the shared divider.
// ----------------------------------------------------------------------------
module ovn_core import ovn_pkg::*;
#(
    parameter int SIDE        = 256,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [COORD_W-1:0]  point_x,
    input  logic [COORD_W-1:0]  point_y,
    input  cfg_t                cfg,
    output logic [STORE_AW-1:0] ram_addr,
    input  logic [SAMPLE_W-1:0] ram_data,
    output logic                done,
    input  logic                ack,
    output logic [SAMPLE_W-1:0] result
);

    localparam int PW      = $clog2(SIDE + 1);
    localparam int OCT_LIM = $clog2(SIDE + 1);
    localparam int RCW     = imax(PW, COORD_W);
    localparam int TW      = SAMPLE_W + PW;
    localparam int NW      = SAMPLE_W + 2 * PW;
    localparam int WW      = SAMPLE_BITS + 2 * (OCT_LIM - 1) + 1;
    localparam int WSW     = WW + 4;
    localparam int AW      = SAMPLE_W + WW + 4;
    localparam int MAW     = imax(SAMPLE_W, PW);
    localparam int MBW     = imax(TW, WW);
    localparam int PRW     = MAW + MBW;
    localparam int DW      = imax(imax(AW, WW + WEIGHT_SHIFT), imax(NW, COORD_W));
    localparam int DVW     = imax(imax(WSW, 2 * PW), imax(BIAS_W, PW));
    localparam int NBW     = $clog2(DW + 1);
    localparam int AFW     = imax(2 * PW, STORE_AW);
    // point modulo SIDE by reciprocal multiply, exact for COORD_W-bit points
    localparam int MOD_SH  = COORD_W + PW;
    localparam int MOD_RCP = ((1 << MOD_SH) + SIDE - 1) / SIDE;
    localparam int MOD_RW  = MOD_SH + COORD_W;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_XM   = 5'd1;
    localparam logic [4:0] S_XMW  = 5'd2;
    localparam logic [4:0] S_YM   = 5'd3;
    localparam logic [4:0] S_YMW  = 5'd4;
    localparam logic [4:0] S_CX   = 5'd5;
    localparam logic [4:0] S_CXW  = 5'd6;
    localparam logic [4:0] S_CY   = 5'd7;
    localparam logic [4:0] S_CYW  = 5'd8;
    localparam logic [4:0] S_R0   = 5'd9;
    localparam logic [4:0] S_R1   = 5'd10;
    localparam logic [4:0] S_R2   = 5'd11;
    localparam logic [4:0] S_R3   = 5'd12;
    localparam logic [4:0] S_R4   = 5'd13;
    localparam logic [4:0] S_M0   = 5'd14;
    localparam logic [4:0] S_M1   = 5'd15;
    localparam logic [4:0] S_M2   = 5'd16;
    localparam logic [4:0] S_M3   = 5'd17;
    localparam logic [4:0] S_M4   = 5'd18;
    localparam logic [4:0] S_M5   = 5'd19;
    localparam logic [4:0] S_M6   = 5'd20;
    localparam logic [4:0] S_DV   = 5'd21;
    localparam logic [4:0] S_DVW  = 5'd22;
    localparam logic [4:0] S_MW   = 5'd23;
    localparam logic [4:0] S_AC   = 5'd24;
    localparam logic [4:0] S_WD   = 5'd25;
    localparam logic [4:0] S_WDW  = 5'd26;
    localparam logic [4:0] S_FD   = 5'd27;
    localparam logic [4:0] S_FDW  = 5'd28;
    localparam logic [4:0] S_DONE = 5'd29;

    logic [4:0]          state_reg;
    logic [4:0]          state_next;
    logic [OCT_W-1:0]    oct_reg;
    logic [OCT_W-1:0]    cnt_lim_reg;

    logic [BIAS_W-1:0]   bias_reg;
    logic [RCW-1:0]      x_reg, y_reg, x1_reg, y1_reg;
    logic [PW-1:0]       dx_reg, dy_reg, p_reg;
    logic [SAMPLE_W-1:0] s00_reg, s01_reg, s10_reg, s11_reg, v_reg;
    logic [NW-1:0]       t_reg, numer_reg;
    logic [TW-1:0]       top_reg, bot_reg;
    logic [WW-1:0]       weight_reg;
    logic [WSW-1:0]      wsum_reg;
    logic [AW-1:0]       acc_reg;
    logic [PRW-1:0]      prod_reg;
    logic [SAMPLE_W-1:0] result_reg;
    logic [COORD_W-1:0]  modq_reg;

    logic [OCT_W-1:0]    cnt_clamp;
    logic [BIAS_W-1:0]   bias_clamp;
    logic [RCW:0]        x_sum, y_sum;
    logic [RCW-1:0]      x2, y2;
    logic [RCW-1:0]      row, col;
    logic [AFW-1:0]      addr_full;
    logic [MAW-1:0]      mul_a;
    logic [MBW-1:0]      mul_b;
    logic [COORD_W-1:0]  mod_src;
    logic [MOD_RW-1:0]   mod_prod;

    logic                div_start;
    logic [NBW-1:0]      div_nbits;
    logic [DW-1:0]       div_dividend;
    logic [DVW-1:0]      div_divisor;
    logic                div_done;
    logic [DW-1:0]       div_quot;
    logic [DVW-1:0]      div_rem;

    ovn_div #(
        .DW  (DW),
        .DVW (DVW),
        .NBW (NBW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .nbits    (div_nbits),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // zero acts as one octave; counts beyond the last unit pitch saturate
    always_comb
    begin
        if (cfg.octave_count == '0)
        begin
            cnt_clamp = OCT_W'(1);
        end
        else if (cfg.octave_count > OCT_W'(OCT_LIM))
        begin
            cnt_clamp = OCT_W'(OCT_LIM);
        end
        else
        begin
            cnt_clamp = cfg.octave_count;
        end

        if (cfg.bias < BIAS_LOW)
        begin
            bias_clamp = BIAS_LOW;
        end
        else if (cfg.bias > BIAS_HIGH)
        begin
            bias_clamp = BIAS_HIGH;
        end
        else
        begin
            bias_clamp = cfg.bias;
        end
    end

    // quotient of the point by SIDE; remainder taken in the next cycle
    assign mod_src  = (state_reg == S_YM) ? y_reg[COORD_W-1:0] : x_reg[COORD_W-1:0];
    assign mod_prod = MOD_RW'(mod_src) * MOD_RW'(MOD_RCP);

    // far corner wraps; x1 + p stays below twice the side
    assign x_sum = (RCW+1)'(x1_reg) + (RCW+1)'(p_reg);
    assign y_sum = (RCW+1)'(y1_reg) + (RCW+1)'(p_reg);
    assign x2 = (x_sum >= (RCW+1)'(SIDE)) ? RCW'(x_sum - (RCW+1)'(SIDE)) : RCW'(x_sum);
    assign y2 = (y_sum >= (RCW+1)'(SIDE)) ? RCW'(y_sum - (RCW+1)'(SIDE)) : RCW'(y_sum);

    always_comb
    begin
        unique case (state_reg)
            S_R0:
            begin
                row = y1_reg;
                col = x1_reg;
            end
            S_R1:
            begin
                row = y1_reg;
                col = x2;
            end
            S_R2:
            begin
                row = y2;
                col = x1_reg;
            end
            S_R3:
            begin
                row = y2;
                col = x2;
            end
            default:
            begin
                row = '0;
                col = '0;
            end
        endcase
    end

    assign addr_full = AFW'(row) * AFW'(SIDE) + AFW'(col);
    assign ram_addr  = addr_full[STORE_AW-1:0];

    // multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            S_M0:
            begin
                mul_a = MAW'(p_reg - dx_reg);
                mul_b = MBW'(s00_reg);
            end
            S_M1:
            begin
                mul_a = MAW'(dx_reg);
                mul_b = MBW'(s01_reg);
            end
            S_M2:
            begin
                mul_a = MAW'(p_reg - dx_reg);
                mul_b = MBW'(s10_reg);
            end
            S_M3:
            begin
                mul_a = MAW'(dx_reg);
                mul_b = MBW'(s11_reg);
            end
            S_M4:
            begin
                mul_a = MAW'(p_reg - dy_reg);
                mul_b = MBW'(top_reg);
            end
            S_M5:
            begin
                mul_a = MAW'(dy_reg);
                mul_b = MBW'(bot_reg);
            end
            S_M6:
            begin
                mul_a = MAW'(p_reg);
                mul_b = MBW'(p_reg);
            end
            S_MW:
            begin
                mul_a = MAW'(v_reg);
                mul_b = MBW'(weight_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider request select
    always_comb
    begin
        div_start    = 1'b0;
        div_nbits    = '0;
        div_dividend = '0;
        div_divisor  = '0;
        unique case (state_reg)
            S_CX:
            begin
                div_start    = 1'b1;
                div_nbits    = NBW'(COORD_W);
                div_dividend = DW'(x_reg);
                div_divisor  = DVW'(p_reg);
            end
            S_CY:
            begin
                div_start    = 1'b1;
                div_nbits    = NBW'(COORD_W);
                div_dividend = DW'(y_reg);
                div_divisor  = DVW'(p_reg);
            end
            S_DV:
            begin
                // prod_reg holds p * p here
                div_start    = 1'b1;
                div_nbits    = NBW'(NW);
                div_dividend = DW'(numer_reg);
                div_divisor  = DVW'(prod_reg[2*PW-1:0]);
            end
            S_WD:
            begin
                div_start    = 1'b1;
                div_nbits    = NBW'(WW + WEIGHT_SHIFT);
                div_dividend = DW'({weight_reg, {WEIGHT_SHIFT{1'b0}}});
                div_divisor  = DVW'(bias_reg);
            end
            S_FD:
            begin
                div_start    = 1'b1;
                div_nbits    = NBW'(AW);
                div_dividend = DW'(acc_reg);
                div_divisor  = DVW'(wsum_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (start) state_next = S_XM;
            S_XM:   state_next = S_XMW;
            S_XMW:  state_next = S_YM;
            S_YM:   state_next = S_YMW;
            S_YMW:  state_next = S_CX;
            S_CX:   state_next = S_CXW;
            S_CXW:  if (div_done) state_next = S_CY;
            S_CY:   state_next = S_CYW;
            S_CYW:  if (div_done) state_next = S_R0;
            S_R0:   state_next = S_R1;
            S_R1:   state_next = S_R2;
            S_R2:   state_next = S_R3;
            S_R3:   state_next = S_R4;
            S_R4:   state_next = S_M0;
            S_M0:   state_next = S_M1;
            S_M1:   state_next = S_M2;
            S_M2:   state_next = S_M3;
            S_M3:   state_next = S_M4;
            S_M4:   state_next = S_M5;
            S_M5:   state_next = S_M6;
            S_M6:   state_next = S_DV;
            S_DV:   state_next = S_DVW;
            S_DVW:  if (div_done) state_next = S_MW;
            S_MW:   state_next = S_AC;
            S_AC:
            begin
                if ((oct_reg + OCT_W'(1)) < cnt_lim_reg)
                begin
                    state_next = S_WD;
                end
                else
                begin
                    state_next = S_FD;
                end
            end
            S_WD:   state_next = S_WDW;
            S_WDW:  if (div_done) state_next = S_CX;
            S_FD:   state_next = S_FDW;
            S_FDW:  if (div_done) state_next = S_DONE;
            S_DONE: if (ack) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            oct_reg     <= '0;
            cnt_lim_reg <= OCT_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_IDLE) && start)
            begin
                oct_reg     <= '0;
                cnt_lim_reg <= cnt_clamp;
            end
            else if ((state_reg == S_WDW) && div_done)
            begin
                oct_reg <= oct_reg + OCT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PRW'(mul_a) * PRW'(mul_b);
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    x_reg      <= RCW'(point_x);
                    y_reg      <= RCW'(point_y);
                    bias_reg   <= bias_clamp;
                    p_reg      <= PW'(SIDE);
                    weight_reg <= WW'(1) << SAMPLE_BITS;
                    acc_reg    <= '0;
                    wsum_reg   <= '0;
                end
            end
            S_XM:  modq_reg <= mod_prod[MOD_RW-1:MOD_SH];
            S_XMW: x_reg    <= x_reg - RCW'(modq_reg) * RCW'(SIDE);
            S_YM:  modq_reg <= mod_prod[MOD_RW-1:MOD_SH];
            S_YMW: y_reg    <= y_reg - RCW'(modq_reg) * RCW'(SIDE);
            S_CXW:
            begin
                if (div_done)
                begin
                    dx_reg <= PW'(div_rem);
                    x1_reg <= x_reg - RCW'(div_rem);
                end
            end
            S_CYW:
            begin
                if (div_done)
                begin
                    dy_reg <= PW'(div_rem);
                    y1_reg <= y_reg - RCW'(div_rem);
                end
            end
            S_R1:  s00_reg <= ram_data;
            S_R2:  s01_reg <= ram_data;
            S_R3:  s10_reg <= ram_data;
            S_R4:  s11_reg <= ram_data;
            S_M1:  t_reg   <= NW'(prod_reg);
            S_M2:  top_reg <= TW'(t_reg + NW'(prod_reg));
            S_M3:  t_reg   <= NW'(prod_reg);
            S_M4:  bot_reg <= TW'(t_reg + NW'(prod_reg));
            S_M5:  t_reg   <= NW'(prod_reg);
            S_M6:  numer_reg <= t_reg + NW'(prod_reg);
            S_DVW: if (div_done) v_reg <= SAMPLE_W'(div_quot);
            S_AC:
            begin
                acc_reg  <= acc_reg + AW'(prod_reg);
                wsum_reg <= wsum_reg + WSW'(weight_reg);
            end
            S_WDW:
            begin
                if (div_done)
                begin
                    weight_reg <= WW'(div_quot);
                    p_reg      <= p_reg >> 1;
                end
            end
            S_FDW: if (div_done) result_reg <= SAMPLE_W'(div_quot);
            default:
            begin
            end
        endcase
    end

    assign done   = (state_reg == S_DONE);
    assign result = result_reg;

    a_oct_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (oct_reg < cnt_lim_reg))
        else $error("octave index ran past the octave count");

endmodule

### hw/rtl/octave_value_noise_2d_top.sv
// ----------------------------------------------------------------------------
// octave_value_noise_2d_top
// A seed write item is written into the store when it is taken. A query
// item runs its octave loop through the bit-serial shared divider, and its
// result goes to the output register; the next item is taken in the cycle
// after that result is loaded.
// One query in flight; reset clears control, loads config defaults, and
// leaves the seed store undefined until written.
// ----------------------------------------------------------------------------
module octave_value_noise_2d_top import ovn_pkg::*;
#(
    parameter int SIDE        = 256,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration write port
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [14:0] cfg_data,

    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // seed_index[15:0], seed_value[31:16],
                                   // point_x[39:32], point_y[47:40]
    input  logic [0:0]  s_tuser,   // func[0]

    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // noise_value[15:0]
);

    cfg_t                cfg_reg;
    logic                busy_reg;
    logic                m_tvalid_reg;
    logic [SAMPLE_W-1:0] m_tdata_reg;

    logic                in_acc;
    logic                seed_we;
    logic                q_start;
    logic                out_free;
    logic                out_load;

    logic [STORE_AW-1:0] core_addr;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic                core_done;
    logic [SAMPLE_W-1:0] core_result;

    // A query holds the input side until its result moves to the output
    // register; seed writes go straight into the store.
    assign s_tready = !busy_reg;
    assign in_acc   = s_tvalid && s_tready;
    assign seed_we  = in_acc && (s_tuser[0] == FUNC_WRITE);
    assign q_start  = in_acc && (s_tuser[0] == FUNC_QUERY);

    // output register frees when empty or being taken this cycle
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = core_done && out_free;

    // configuration registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.octave_count <= OCT_COUNT_RST;
            cfg_reg.bias         <= BIAS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index[0])
                REG_OCTAVE_COUNT: cfg_reg.octave_count <= cfg_data[OCT_W-1:0];
                REG_BIAS:         cfg_reg.bias         <= cfg_data[BIAS_W-1:0];
                default:          cfg_reg.bias         <= cfg_reg.bias;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (q_start)
            begin
                busy_reg <= 1'b1;
            end
            else if (out_load)
            begin
                busy_reg <= 1'b0;
            end

            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= core_result;
        end
    end

    ovn_seed_ram u_seed_ram (
        .clk   (clk),
        .we    (seed_we),
        .waddr (s_tdata[15:0]),
        .wdata (s_tdata[31:16]),
        .raddr (core_addr),
        .rdata (ram_rdata)
    );

    ovn_core #(
        .SIDE        (SIDE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (q_start),
        .point_x  (s_tdata[39:32]),
        .point_y  (s_tdata[47:40]),
        .cfg      (cfg_reg),
        .ram_addr (core_addr),
        .ram_data (ram_rdata),
        .done     (core_done),
        .ack      (out_load),
        .result   (core_result)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_start |=> busy_reg)
        else $error("query accepted without going busy");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (core_done && !out_free) |=> core_done)
        else $error("finished result dropped while output was full");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        core_done |-> busy_reg)
        else $error("core finished with no query outstanding");

endmodule
